/* hdl/waiting_queue_sort_by_duration_defines.svh */
// Assertion macros for the waiting queue block.
// Used by waiting_queue_sort_by_duration.sv; expects clk and rst_n in scope.
`ifndef WAITING_QUEUE_SORT_BY_DURATION_DEFINES_SVH
`define WAITING_QUEUE_SORT_BY_DURATION_DEFINES_SVH

// same-cycle implication
`define WQSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WQSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wqsd_pkg.sv */
// Shared types and constants for the waiting queue block.
// No dependencies.
`default_nettype none

package wqsd_pkg;

    localparam int PID_W     = 22;
    localparam int DATA_W    = 16;
    localparam int CNT_OUT_W = 5;
    localparam int DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_SORT   = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [PID_W-1:0]  proc_id;
        logic [DATA_W-1:0] arrive_time;
        logic [DATA_W-1:0] run_time;
        logic [DATA_W-1:0] tag_value;
        logic [DATA_W-1:0] wait_delay;
        logic [DATA_W-1:0] mem_size;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic load;
        logic step;
    } bub_ctl_t;

endpackage

`default_nettype wire

/* hdl/wqsd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wqsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/wqsd_bubble_unit.sv */
// Compare-and-carry unit for one bubble pass: holds the carried entry,
// compares durations, emits the smaller for write-back. Uses wqsd_pkg.
`default_nettype none

module wqsd_bubble_unit (
    input  wire logic              clk,
    input  wire wqsd_pkg::bub_ctl_t ctl,
    input  wire wqsd_pkg::entry_t  rd_entry,
    output wqsd_pkg::entry_t       wr_entry,
    output wqsd_pkg::entry_t       carry
);

    wqsd_pkg::entry_t carry_reg;
    wqsd_pkg::entry_t carry_next;
    logic             swap;

    always_comb
    begin
        swap       = carry_reg.run_time > rd_entry.run_time;
        wr_entry   = swap ? rd_entry : carry_reg;
        carry_next = carry_reg;
        if (ctl.load)
        begin
            carry_next = rd_entry;
        end
        else if (ctl.step)
        begin
            carry_next = swap ? carry_reg : rd_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    assign carry = carry_reg;

endmodule

`default_nettype wire

/* hdl/waiting_queue_sort_by_duration.sv */
// Waiting queue top level: sequencer, circular-buffer pointers, result register.
// Uses wqsd_pkg, wqsd_ram, wqsd_bubble_unit and the assertion macro header.
//
// Usage:
//   Command channel (cmd_valid/cmd_ready) carries action and the entry fields.
//   Result channel (res_valid/res_ready) returns one transaction per command:
//   popped entry (out_*), non_empty, entry_count and status.
//   cmd_ready is high only while the sequencer is idle; one command at a time.
//   The result is registered in S_FINISH, entered straight from accept for query,
//   pop on empty and sort on fewer than 2 entries, via S_INSERT for insert, via
//   S_POP_RD for pop, and via S_SORT_START, S_SORT_LOAD, S_SORT_STEP, S_SORT_END
//   for sort on n >= 2 entries; the sequencer is then idle for the next command.
//   Sort uses the one shared comparator: n-1 passes, each step one read and one
//   write of the entry RAM, carrying the larger entry.
//   Results sit in an output register; a command is accepted while a result
//   waits. If res_ready is low when the next result is ready, the sequencer
//   holds in its final state until the register drains.
//   Reset clears the pointers and the count (empty queue, no result pending).
//   Entry RAM is not cleared; only written entries are ever read.
`default_nettype none
`include "waiting_queue_sort_by_duration_defines.svh"

module waiting_queue_sort_by_duration #(
    parameter int DEPTH = wqsd_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire logic [1:0]                    action,
    input  wire logic [wqsd_pkg::PID_W-1:0]    proc_id,
    input  wire logic [wqsd_pkg::DATA_W-1:0]   arrive_time,
    input  wire logic [wqsd_pkg::DATA_W-1:0]   run_time,
    input  wire logic [wqsd_pkg::DATA_W-1:0]   tag_value,
    input  wire logic [wqsd_pkg::DATA_W-1:0]   wait_delay,
    input  wire logic [wqsd_pkg::DATA_W-1:0]   mem_size,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic                               out_valid,
    output logic      [wqsd_pkg::PID_W-1:0]    out_proc_id,
    output logic      [wqsd_pkg::DATA_W-1:0]   out_arrive_time,
    output logic      [wqsd_pkg::DATA_W-1:0]   out_run_time,
    output logic      [wqsd_pkg::DATA_W-1:0]   out_tag_value,
    output logic      [wqsd_pkg::DATA_W-1:0]   out_wait_delay,
    output logic      [wqsd_pkg::DATA_W-1:0]   out_mem_size,
    output logic                               non_empty,
    output logic      [wqsd_pkg::CNT_OUT_W-1:0] entry_count,
    output logic      [1:0]                    status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INSERT,
        S_POP_RD,
        S_SORT_START,
        S_SORT_LOAD,
        S_SORT_STEP,
        S_SORT_END,
        S_FINISH
    } state_t;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + AW'(1);
        end
        return r;
    endfunction

    state_t                  state_reg, state_next;
    wqsd_pkg::op_t           op_reg, op_next;
    wqsd_pkg::entry_t        ent_reg, ent_next;
    wqsd_pkg::status_t       st_reg, st_next;
    logic                    hit_reg, hit_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [AW-1:0]           rd_slot_reg, rd_slot_next;
    logic [AW-1:0]           wr_slot_reg, wr_slot_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           pass_reg, pass_next;
    logic                    res_valid_reg, res_valid_next;
    logic                    res_hit_reg, res_hit_next;
    wqsd_pkg::entry_t        res_ent_reg, res_ent_next;
    logic                    res_ne_reg, res_ne_next;
    logic [wqsd_pkg::CNT_OUT_W-1:0] res_cnt_reg, res_cnt_next;
    wqsd_pkg::status_t       res_st_reg, res_st_next;

    logic                    cmd_fire;
    logic                    out_free;
    logic [SW-1:0]           tail_sum;
    logic [AW-1:0]           tail_slot;
    logic [CW-1:0]           count_fin;
    logic [CW+4:0]           count_wide;
    wqsd_pkg::entry_t        cmd_entry;

    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    wqsd_pkg::entry_t        ram_wr_data;
    logic                    ram_rd_en;
    logic [AW-1:0]           ram_rd_addr;
    wqsd_pkg::entry_t        ram_rd_data;

    wqsd_pkg::bub_ctl_t      bub_ctl;
    wqsd_pkg::entry_t        bub_wr_entry;
    wqsd_pkg::entry_t        bub_carry;

    wqsd_ram #(
        .WIDTH (wqsd_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    wqsd_bubble_unit u_bubble (
        .clk      (clk),
        .ctl      (bub_ctl),
        .rd_entry (ram_rd_data),
        .wr_entry (bub_wr_entry),
        .carry    (bub_carry)
    );

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign out_free  = !res_valid_reg || res_ready;

    assign cmd_entry.proc_id     = proc_id;
    assign cmd_entry.arrive_time = arrive_time;
    assign cmd_entry.run_time    = run_time;
    assign cmd_entry.tag_value   = tag_value;
    assign cmd_entry.wait_delay  = wait_delay;
    assign cmd_entry.mem_size    = mem_size;

    assign tail_sum   = SW'(head_reg) + SW'(count_reg);
    assign tail_slot  = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign count_fin  = hit_reg ? (count_reg - CW'(1)) : count_reg;
    assign count_wide = (CW+5)'(count_fin);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ent_next       = ent_reg;
        st_next        = st_reg;
        hit_next       = hit_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        rd_slot_next   = rd_slot_reg;
        wr_slot_next   = wr_slot_reg;
        idx_next       = idx_reg;
        pass_next      = pass_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_hit_next   = res_hit_reg;
        res_ent_next   = res_ent_reg;
        res_ne_next    = res_ne_reg;
        res_cnt_next   = res_cnt_reg;
        res_st_next    = res_st_reg;

        ram_wr_en      = 1'b0;
        ram_wr_addr    = wr_slot_reg;
        ram_wr_data    = bub_wr_entry;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = rd_slot_reg;
        bub_ctl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next  = wqsd_pkg::op_t'(action);
                    ent_next = cmd_entry;
                    st_next  = wqsd_pkg::ST_OK;
                    hit_next = 1'b0;
                    unique case (wqsd_pkg::op_t'(action))
                        wqsd_pkg::OP_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                st_next = wqsd_pkg::ST_FULL;
                            end
                            state_next = S_INSERT;
                        end
                        wqsd_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next    = wqsd_pkg::ST_EMPTY;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                hit_next   = 1'b1;
                                state_next = S_POP_RD;
                            end
                        end
                        wqsd_pkg::OP_SORT:
                        begin
                            pass_next  = '0;
                            state_next = (count_reg < CW'(2)) ? S_FINISH : S_SORT_START;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_INSERT:
            begin
                if (st_reg == wqsd_pkg::ST_OK)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = tail_slot;
                    ram_wr_data = ent_reg;
                    count_next  = count_reg + CW'(1);
                end
                state_next = S_FINISH;
            end

            S_POP_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = head_reg;
                state_next  = S_FINISH;
            end

            S_SORT_START:
            begin
                ram_rd_en    = 1'b1;
                ram_rd_addr  = head_reg;
                rd_slot_next = slot_inc(head_reg);
                wr_slot_next = head_reg;
                idx_next     = CW'(1);
                state_next   = S_SORT_LOAD;
            end

            S_SORT_LOAD:
            begin
                bub_ctl.load = 1'b1;
                ram_rd_en    = 1'b1;
                rd_slot_next = slot_inc(rd_slot_reg);
                state_next   = S_SORT_STEP;
            end

            S_SORT_STEP:
            begin
                // write back the smaller, carry the larger
                bub_ctl.step = 1'b1;
                ram_wr_en    = 1'b1;
                wr_slot_next = slot_inc(wr_slot_reg);
                if ((CW+1)'(idx_reg) + (CW+1)'(1) < (CW+1)'(count_reg))
                begin
                    ram_rd_en    = 1'b1;
                    rd_slot_next = slot_inc(rd_slot_reg);
                    idx_next     = idx_reg + CW'(1);
                end
                else
                begin
                    state_next = S_SORT_END;
                end
            end

            S_SORT_END:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = bub_carry;
                if ((CW+1)'(pass_reg) + (CW+1)'(2) >= (CW+1)'(count_reg))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    pass_next  = pass_reg + CW'(1);
                    state_next = S_SORT_START;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_hit_next   = hit_reg;
                    res_ent_next   = hit_reg ? ram_rd_data : '0;
                    res_ne_next    = (count_fin != '0);
                    res_cnt_next   = count_wide[wqsd_pkg::CNT_OUT_W-1:0];
                    res_st_next    = st_reg;
                    count_next     = count_fin;
                    if (hit_reg)
                    begin
                        head_next = slot_inc(head_reg);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= wqsd_pkg::OP_QUERY;
            ent_reg       <= '0;
            st_reg        <= wqsd_pkg::ST_OK;
            hit_reg       <= 1'b0;
            count_reg     <= '0;
            head_reg      <= '0;
            rd_slot_reg   <= '0;
            wr_slot_reg   <= '0;
            idx_reg       <= '0;
            pass_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_hit_reg   <= 1'b0;
            res_ent_reg   <= '0;
            res_ne_reg    <= 1'b0;
            res_cnt_reg   <= '0;
            res_st_reg    <= wqsd_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            ent_reg       <= ent_next;
            st_reg        <= st_next;
            hit_reg       <= hit_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            rd_slot_reg   <= rd_slot_next;
            wr_slot_reg   <= wr_slot_next;
            idx_reg       <= idx_next;
            pass_reg      <= pass_next;
            res_valid_reg <= res_valid_next;
            res_hit_reg   <= res_hit_next;
            res_ent_reg   <= res_ent_next;
            res_ne_reg    <= res_ne_next;
            res_cnt_reg   <= res_cnt_next;
            res_st_reg    <= res_st_next;
        end
    end

    assign res_valid       = res_valid_reg;
    assign out_valid       = res_hit_reg;
    assign out_proc_id     = res_ent_reg.proc_id;
    assign out_arrive_time = res_ent_reg.arrive_time;
    assign out_run_time    = res_ent_reg.run_time;
    assign out_tag_value   = res_ent_reg.tag_value;
    assign out_wait_delay  = res_ent_reg.wait_delay;
    assign out_mem_size    = res_ent_reg.mem_size;
    assign non_empty       = res_ne_reg;
    assign entry_count     = res_cnt_reg;
    assign status          = res_st_reg;

    // op_reg records the command for debug visibility in the sort path
    logic sort_busy;
    assign sort_busy = (op_reg == wqsd_pkg::OP_SORT) && (state_reg != S_IDLE);

    `WQSD_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "occupancy above depth")
    `WQSD_ASSERT_NOW(a_pop_status, res_valid_reg && res_hit_reg,
        res_st_reg == wqsd_pkg::ST_OK, "popped entry with error status")
    `WQSD_ASSERT_NEXT(a_one_at_a_time, cmd_fire, !cmd_ready, "command accepted while busy")
    `WQSD_ASSERT_NOW(a_sort_no_write_idle, ram_wr_en && (state_reg != S_INSERT),
        sort_busy, "entry RAM written outside insert or sort")

endmodule

`default_nettype wire
